@@ rtl/stack_grown_two_level_page_map_macros.svh @@
// Assertion macros for the page map RTL.
`ifndef STACK_GROWN_TWO_LEVEL_PAGE_MAP_MACROS_SVH
`define STACK_GROWN_TWO_LEVEL_PAGE_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGTPM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGTPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sgtpm_pkg.sv @@
package sgtpm_pkg;

  localparam int SLOT_W = 16;
  localparam int PAGE_FIELD_W = 24;

  localparam logic [1:0] CMD_SEIZE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_NO_DATA = 3'd2,
    ST_NO_LEAF = 3'd3,
    ST_BAD = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] slot;
    logic [23:0] data_page;
    logic data_page_ok;
    logic [23:0] map_page;
    logic map_page_ok;
  } req_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] slot_index;
    logic [23:0] result_page;
    logic give_back_data;
    logic leaf_taken;
    logic leaf_freed;
    logic [23:0] freed_map_page;
  } rsp_word_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_valid;
  } dp_status_t;

endpackage

@@ rtl/stack_grown_two_level_page_map.sv @@
// Two-level page map that grows and shrinks at the top like a stack.
// Request channel req (req_valid, req_stall) carries one command word:
// seize the next slot, release the top slot, or look up a slot. Response
// channel rsp (rsp_valid, rsp_stall) returns exactly one word per request.
// A word is accepted on a rising edge with valid high and stall low.
// Steps: the accepting edge (S_IDLE) reads the entry and leaf directory
// memories into registers; the update step (S_EXEC) writes them and the
// top pointer and loads the response word, and waits while an earlier
// response word is stalled. A new request is taken only after the update
// step of the last one completes.
// Leaves hold 2**LEAF_INDEX_BITS slots; pages keep min(PAGE_BITS, 24) bits.
// Reset empties the map at once: no clearing pass runs, because presence
// follows from the top pointer. Stored pages are not cleared.
// While the response word is stalled it holds, and a request already
// taken waits in its update step; req_stall stays high until it completes.
module stack_grown_two_level_page_map #(
  parameter int LEAF_INDEX_BITS = 8,
  parameter int PAGE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  sgtpm_pkg::req_word_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output sgtpm_pkg::rsp_word_t  rsp
);

  localparam int PAGE_W =
    (PAGE_BITS < sgtpm_pkg::PAGE_FIELD_W) ? PAGE_BITS : sgtpm_pkg::PAGE_FIELD_W;

  sgtpm_pkg::ctrl_cmd_t cmd;
  sgtpm_pkg::dp_status_t dp_status;

  sgtpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_stall (rsp_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  sgtpm_dp #(
    .LEAF_INDEX_BITS (LEAF_INDEX_BITS),
    .PAGE_W          (PAGE_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .dp_status (dp_status),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

@@ rtl/sgtpm_ctrl.sv @@
module sgtpm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   rsp_stall,
  input  sgtpm_pkg::dp_status_t  dp_status,
  output sgtpm_pkg::ctrl_cmd_t   cmd
);

  sgtpm_pkg::state_e state;
  sgtpm_pkg::state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgtpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    req_stall = 1'b1;
    case (state)
      sgtpm_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = sgtpm_pkg::S_EXEC;
        end
      end
      sgtpm_pkg::S_EXEC: begin
        if (!(dp_status.rsp_valid && rsp_stall)) begin
          cmd.execute = 1'b1;
          state_next = sgtpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sgtpm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sgtpm_dp.sv @@
`include "stack_grown_two_level_page_map_macros.svh"

module sgtpm_dp #(
  parameter int LEAF_INDEX_BITS = 8,
  parameter int PAGE_W = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sgtpm_pkg::req_word_t   req,
  input  sgtpm_pkg::ctrl_cmd_t   cmd,
  output sgtpm_pkg::dp_status_t  dp_status,
  input  logic                   rsp_stall,
  output logic                   rsp_valid,
  output sgtpm_pkg::rsp_word_t   rsp
);

  localparam int SLOT_W = sgtpm_pkg::SLOT_W;
  localparam int PFW = sgtpm_pkg::PAGE_FIELD_W;
  localparam int LEAF_W = SLOT_W - LEAF_INDEX_BITS;
  localparam int SLOTS = 1 << SLOT_W;
  localparam int LEAVES = 1 << LEAF_W;

  // Every slot at or below the top holds a nonzero page, and exactly the
  // leaves up to the top's leaf are present, so both stores are tracked by
  // the top pointer alone.
  logic [PAGE_W-1:0] entry_mem [SLOTS];
  logic [PAGE_W-1:0] dir_mem [LEAVES];

  sgtpm_pkg::req_word_t cur;
  logic [PAGE_W-1:0] entry_rd;
  logic [PAGE_W-1:0] dir_rd;
  logic [SLOT_W-1:0] top_slot;
  logic top_valid;

  logic [SLOT_W-1:0] top_slot_next;
  logic top_valid_next;
  logic [PAGE_W-1:0] dpage;
  logic [PAGE_W-1:0] lpage;
  logic [SLOT_W-1:0] next_slot;
  logic new_leaf;
  logic full;
  logic ent_we;
  logic dir_we;
  sgtpm_pkg::rsp_word_t res;

  assign dp_status.rsp_valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      entry_rd <= entry_mem[req.slot];
    end
    if (cmd.execute && ent_we) begin
      entry_mem[next_slot] <= dpage;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dir_rd <= dir_mem[req.slot[SLOT_W-1:LEAF_INDEX_BITS]];
    end
    if (cmd.execute && dir_we) begin
      dir_mem[next_slot[SLOT_W-1:LEAF_INDEX_BITS]] <= lpage;
    end
  end

  always_comb begin
    dpage = cur.data_page[PAGE_W-1:0];
    lpage = cur.map_page[PAGE_W-1:0];
    full = top_valid && (top_slot == '1);
    new_leaf = !top_valid || (top_slot[LEAF_INDEX_BITS-1:0] == '1);
    next_slot = top_valid ? SLOT_W'(top_slot + 1'b1) : '0;

    res = '0;
    res.status = sgtpm_pkg::ST_BAD;
    top_slot_next = top_slot;
    top_valid_next = top_valid;
    ent_we = 1'b0;
    dir_we = 1'b0;

    case (cur.cmd)
      sgtpm_pkg::CMD_SEIZE: begin
        if (full) begin
          res.status = sgtpm_pkg::ST_FULL;
        end else if (!cur.data_page_ok) begin
          res.status = sgtpm_pkg::ST_NO_DATA;
        end else if (dpage == '0) begin
          res.status = sgtpm_pkg::ST_BAD;
        end else if (new_leaf && (!cur.map_page_ok || lpage == '0)) begin
          res.status = cur.map_page_ok ? sgtpm_pkg::ST_BAD : sgtpm_pkg::ST_NO_LEAF;
          res.result_page = PFW'(dpage);
          res.give_back_data = 1'b1;
        end else begin
          dir_we = new_leaf;
          ent_we = 1'b1;
          res.leaf_taken = new_leaf;
          res.status = sgtpm_pkg::ST_OK;
          res.slot_index = next_slot;
          res.result_page = PFW'(dpage);
          top_slot_next = next_slot;
          top_valid_next = 1'b1;
        end
      end
      sgtpm_pkg::CMD_RELEASE: begin
        if (top_valid && cur.slot == top_slot) begin
          res.status = sgtpm_pkg::ST_OK;
          res.result_page = PFW'(entry_rd);
          res.give_back_data = 1'b1;
          if (cur.slot[LEAF_INDEX_BITS-1:0] == '0) begin
            res.leaf_freed = 1'b1;
            res.freed_map_page = PFW'(dir_rd);
          end
          if (cur.slot == '0) begin
            top_slot_next = '0;
            top_valid_next = 1'b0;
          end else begin
            top_slot_next = SLOT_W'(cur.slot - 1'b1);
          end
        end
      end
      sgtpm_pkg::CMD_LOOKUP: begin
        if (top_valid && cur.slot <= top_slot) begin
          res.status = sgtpm_pkg::ST_OK;
          res.result_page = PFW'(entry_rd);
        end
      end
      default: begin
        res.status = sgtpm_pkg::ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_slot <= '0;
      top_valid <= 1'b0;
    end else if (cmd.execute) begin
      top_slot <= top_slot_next;
      top_valid <= top_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.execute) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp <= res;
    end
  end

  `SGTPM_ASSERT_NEXT(a_no_double_capture, clk, rst, cmd.capture, !cmd.capture, "capture repeated")
  `SGTPM_ASSERT_SAME(a_exec_free, clk, rst, cmd.execute, !(rsp_valid && rsp_stall), "overwrite")
  `SGTPM_ASSERT_SAME(a_empty_top, clk, rst, !top_valid, top_slot == '0, "empty map with top")
  `SGTPM_ASSERT_NEXT(a_top_hold, clk, rst, !cmd.execute, $stable(top_slot), "top moved idle")
  `SGTPM_ASSERT_SAME(a_leaf_free_ok, clk, rst, rsp_valid && rsp.leaf_freed, rsp.status == sgtpm_pkg::ST_OK && rsp.give_back_data, "bad leaf free")

endmodule
